// File: rtl/core/smtp_dsn_pkg.sv
// shared types and constants for the smtp dot-stuffing and crlf normalizer
package smtp_dsn_pkg;

    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // most bytes that one input byte can expand into
    localparam int MAX_BYTES = 6;
    localparam int SLOT_W    = $clog2(MAX_BYTES);
    localparam int COUNT_W   = $clog2(MAX_BYTES + 1);

    // one classified request: the bytes to send, how many, and the end-of-body mark
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } cmd_t;

endpackage

// File: rtl/core/smtp_dot_stuff_crlf_normalizer.sv
// top level of the smtp body dot-stuffing and crlf line-ending normalizer
//
// usage:
//   the s_ channel takes the message body one byte per request, s_tlast on the
//   final byte. the m_ channel returns the transformed body: a dot at the start
//   of a line is doubled, cr lf / lone cr / lone lf all become cr lf, and the
//   body is closed with cr lf unless it already ends at a line start. m_tlast
//   marks the final output byte of the body.
//   a cr is held in a pending bit until the next byte arrives; on the final
//   byte it is settled at once. a cr that is held produces no output yet.
// output path and throughput:
//   a request's bytes pass the request queue, then the output register, to m_.
//   while m_tready is high the output side emits one byte per cycle and plain
//   text runs at one byte per cycle; a request of up to 6 bytes holds the byte
//   sequencer until its last byte loads, and s_ stalls once the queue fills.
// reset and stalls:
//   aresetn (synchronous, active low) empties the queue and the output register
//   and returns the line state to the start of a line with no cr held.
//   when m_tready is low the output register holds; the front end keeps taking
//   bytes until the request queue of QUEUE_DEPTH entries fills, then drops s_tready.
module smtp_dot_stuff_crlf_normalizer
    import smtp_dsn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);

    // request path from the classifier into the queue
    cmd_t push_cmd;
    logic push;
    // queue head seen by the byte sequencer
    cmd_t head_cmd;
    logic pop;
    logic q_empty;
    logic q_full;

    // front end: line state, dot stuffing and crlf decisions, one byte per cycle while the queue has room
    smtp_dsn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    // decouples input acceptance from output expansion
    smtp_dsn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back end: one output byte per cycle into a registered master port while requests wait and m_tready is high
    smtp_dsn_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/core/smtp_dsn_front.sv
// front end: takes body bytes, tracks line state and builds the expansion of each byte
module smtp_dsn_front
    import smtp_dsn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_last
    input  logic       q_full,
    output logic       push,
    output cmd_t       cmd
);

    logic line_start_reg, line_start_next;
    logic pending_reg, pending_next;
    logic accept;
    logic consumed;
    logic [COUNT_W-1:0] n;

    assign s_tready = ~q_full;
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        cmd             = '0;
        n               = '0;
        consumed        = 1'b0;
        line_start_next = line_start_reg;
        pending_next    = 1'b0;

        // settle a held cr first
        if (pending_reg) begin
            cmd.bytes[SLOT_W'(n)] = CH_CR;
            n = n + 1'b1;
            cmd.bytes[SLOT_W'(n)] = CH_LF;
            n = n + 1'b1;
            line_start_next = 1'b1;
            if (s_tdata == CH_LF) begin
                consumed = 1'b1;
            end
        end

        if (!consumed) begin
            if (line_start_next && s_tdata == CH_DOT) begin
                cmd.bytes[SLOT_W'(n)] = CH_DOT;
                n = n + 1'b1;
            end
            if (s_tdata == CH_CR) begin
                if (s_tlast) begin
                    cmd.bytes[SLOT_W'(n)] = CH_CR;
                    n = n + 1'b1;
                    cmd.bytes[SLOT_W'(n)] = CH_LF;
                    n = n + 1'b1;
                    line_start_next = 1'b1;
                end else begin
                    pending_next = 1'b1;
                end
            end else if (s_tdata == CH_LF) begin
                cmd.bytes[SLOT_W'(n)] = CH_CR;
                n = n + 1'b1;
                cmd.bytes[SLOT_W'(n)] = CH_LF;
                n = n + 1'b1;
                line_start_next = 1'b1;
            end else begin
                cmd.bytes[SLOT_W'(n)] = s_tdata;
                n = n + 1'b1;
                line_start_next = 1'b0;
            end
        end

        // close the body on a line boundary and return to reset state
        if (s_tlast) begin
            if (!line_start_next) begin
                cmd.bytes[SLOT_W'(n)] = CH_CR;
                n = n + 1'b1;
                cmd.bytes[SLOT_W'(n)] = CH_LF;
                n = n + 1'b1;
            end
            line_start_next = 1'b1;
            pending_next    = 1'b0;
        end

        cmd.count = n;
        cmd.last  = s_tlast;
    end

    // a held cr produces nothing yet
    assign push = accept & (n != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_start_reg <= 1'b1;
            pending_reg    <= 1'b0;
        end else if (accept) begin
            line_start_reg <= line_start_next;
            pending_reg    <= pending_next;
        end
    end

endmodule

// File: rtl/core/smtp_dsn_queue.sv
// short request queue between the front end and the byte sequencer
module smtp_dsn_queue
    import smtp_dsn_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/smtp_dsn_back.sv
// back end: walks the bytes of each queued request into the output register
module smtp_dsn_back
    import smtp_dsn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       head_cmd,
    input  logic       q_empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast    // out_last
);

    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [7:0]        data_reg, data_next;
    logic              last_reg, last_next;
    logic              load;
    logic              final_slot;

    assign load       = ~q_empty & (~valid_reg | m_tready);
    assign final_slot = (COUNT_W'(idx_reg) + 1'b1 == head_cmd.count);
    assign pop        = load & final_slot;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = head_cmd.bytes[idx_reg];
            last_next  = head_cmd.last & final_slot;
            idx_next   = final_slot ? '0 : idx_reg + 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule
